// ===== rtl/rrxc_pkg.sv =====
// Shared types and helpers for the reverse rotate-XOR checksum block.
`default_nettype none

package rrxc_pkg;

    localparam int unsigned SUM_W   = 32;
    localparam int unsigned LEFT_W  = 30;
    localparam int unsigned ROT_W   = 3;
    localparam int unsigned OUT_W   = 40;

    localparam logic [SUM_W-1:0] SUM_INIT = {SUM_W{1'b1}};

    localparam logic [LEFT_W-1:0] MASK_32 = LEFT_W'(32'h0000_001F);
    localparam logic [LEFT_W-1:0] MASK_1K = LEFT_W'(32'h0000_03FF);
    localparam logic [LEFT_W-1:0] MASK_32K = LEFT_W'(32'h0000_7FFF);
    localparam logic [LEFT_W-1:0] MASK_1M = LEFT_W'(32'h000F_FFFF);

    localparam logic CFG_TOTAL_BYTES  = 1'b0;
    localparam logic CFG_EXPECTED_SUM = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum_value;
        logic             sum_matches;
    } result_t;

    function automatic logic [ROT_W-1:0] rotate_amount(input logic [LEFT_W-1:0] k);
        logic [ROT_W-1:0] n;
        n = ROT_W'(1);
        if ((k & MASK_32) == '0) begin
            n = ROT_W'(2);
            if ((k & MASK_1K) == '0) begin
                n = ROT_W'(3);
                if ((k & MASK_32K) == '0) begin
                    n = ROT_W'(4);
                    if ((k & MASK_1M) == '0) begin
                        n = ROT_W'(5);
                    end
                end
            end
        end
        return n;
    endfunction

    function automatic logic [SUM_W-1:0] rotr(input logic [SUM_W-1:0] x,
                                              input logic [ROT_W-1:0] n);
        logic [2*SUM_W-1:0] wide;
        wide = {x, x} >> n;
        return wide[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/reverse_rotate_xor_checksum_top.sv =====
// Top level of the reverse rotate-XOR checksum block.
// Words of the region arrive on the s_ channel, last word first; the first item of a
// pass is the zero-padded tail word. The user must write the region length and the
// expected checksum through cfg_we, cfg_index and cfg_data while the block is idle;
// the block itself does not enforce this. One result item per pass leaves on the
// m_ channel after the pass's last word. An item is accepted every cycle while
// s_tready is high; after a pass's first word, the per-word step is one rotate by
// one to five places and an XOR between the input register and the state registers.
// The last word's result is registered in the output register, which drives
// m_tvalid. When the receiver stalls with a result pending, the input register
// still takes one more word, and s_tready drops only when both registers are full.
// Reset clears both registers, drops any pass in progress, sets the running sum to
// all ones and sets the length and expected checksum to zero.
`default_nettype none

module reverse_rotate_xor_checksum_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rrxc_pkg::SUM_W-1:0]   s_tdata,  // [31:0] data_word
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [rrxc_pkg::OUT_W-1:0]        m_tdata,  // [31:0] sum_value, [32] sum_matches
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [rrxc_pkg::SUM_W-1:0]   cfg_data
);

    logic [rrxc_pkg::SUM_W-1:0] total_bytes_reg;
    logic [rrxc_pkg::SUM_W-1:0] expected_sum_reg;
    logic                       item_valid;
    logic [rrxc_pkg::SUM_W-1:0] item_data;
    logic                       out_free;
    logic                       take;
    logic                       res_valid;
    rrxc_pkg::result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_bytes_reg  <= '0;
            expected_sum_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrxc_pkg::CFG_TOTAL_BYTES:  total_bytes_reg  <= cfg_data;
                rrxc_pkg::CFG_EXPECTED_SUM: expected_sum_reg <= cfg_data;
                default:                    total_bytes_reg  <= total_bytes_reg;
            endcase
        end
    end

    assign take = item_valid && out_free;

    rrxc_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item_data  (item_data)
    );

    rrxc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .item_data    (item_data),
        .total_bytes  (total_bytes_reg),
        .expected_sum (expected_sum_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    rrxc_output_stage u_output (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/rrxc_input_stage.sv =====
// Input register stage that holds one accepted data word.
`default_nettype none

module rrxc_input_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [rrxc_pkg::SUM_W-1:0] s_tdata,
    input  wire logic                      take,
    output logic                           item_valid,
    output logic [rrxc_pkg::SUM_W-1:0]     item_data
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [rrxc_pkg::SUM_W-1:0] data_reg;

    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/rrxc_core.sv =====
// Checksum state and the rotate-XOR step for one word.
`default_nettype none

module rrxc_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       take,
    input  wire logic [rrxc_pkg::SUM_W-1:0] item_data,
    input  wire logic [rrxc_pkg::SUM_W-1:0] total_bytes,
    input  wire logic [rrxc_pkg::SUM_W-1:0] expected_sum,
    output logic                            res_valid,
    output rrxc_pkg::result_t               res
);

    logic [rrxc_pkg::SUM_W-1:0]  running_sum_reg;
    logic [rrxc_pkg::SUM_W-1:0]  running_sum_next;
    logic [rrxc_pkg::LEFT_W-1:0] words_left_reg;
    logic [rrxc_pkg::LEFT_W-1:0] words_left_next;
    logic                        in_progress_reg;
    logic                        in_progress_next;
    logic [rrxc_pkg::LEFT_W-1:0] start_left;
    logic [rrxc_pkg::LEFT_W-1:0] full_words;

    assign full_words = total_bytes[rrxc_pkg::SUM_W-1:2];

    always_comb
    begin
        start_left = full_words;
        if (total_bytes[1:0] == 2'b00 && full_words != '0)
        begin
            start_left = full_words - rrxc_pkg::LEFT_W'(1);
        end
    end

    always_comb
    begin
        running_sum_next = running_sum_reg;
        words_left_next  = words_left_reg;
        in_progress_next = in_progress_reg;
        if (take)
        begin
            if (!in_progress_reg)
            begin
                running_sum_next = rrxc_pkg::SUM_INIT ^ item_data;
                words_left_next  = start_left;
                in_progress_next = (start_left != '0);
            end
            else
            begin
                running_sum_next = rrxc_pkg::rotr(running_sum_reg,
                    rrxc_pkg::rotate_amount(words_left_reg)) ^ item_data;
                words_left_next  = words_left_reg - rrxc_pkg::LEFT_W'(1);
                in_progress_next = (words_left_next != '0);
            end
        end
    end

    assign res_valid       = take && !in_progress_next;
    assign res.sum_value   = running_sum_next;
    assign res.sum_matches = (running_sum_next == expected_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= rrxc_pkg::SUM_INIT;
            words_left_reg  <= '0;
            in_progress_reg <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            words_left_reg  <= words_left_next;
            in_progress_reg <= in_progress_next;
        end
    end

`ifndef ASSERT_OFF
    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_progress_reg |-> words_left_reg == '0)
        else $error("Idle with words still counted.");

    a_result_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> take)
        else $error("Result without an item taken.");

    a_last_word_ends: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_progress_reg && words_left_reg == rrxc_pkg::LEFT_W'(1)
        |=> !in_progress_reg)
        else $error("Pass did not end on the last word.");

    a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(running_sum_reg))
        else $error("Sum changed without an item.");
`endif

endmodule

`default_nettype wire

// ===== rtl/rrxc_output_stage.sv =====
// Output register stage that holds one result item for the receiver.
`default_nettype none

module rrxc_output_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire rrxc_pkg::result_t           res,
    output logic                             free,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [rrxc_pkg::OUT_W-1:0]       m_tdata
);

    logic              valid_reg;
    logic              valid_next;
    rrxc_pkg::result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0, res_reg.sum_matches, res_reg.sum_value};

endmodule

`default_nettype wire
